// ----- hdl/burner_ignition_safety_core_assert.svh -----
// ----------------------------------------------------------------------------
// Burner ignition safety core assertion macros
// Concurrent check helpers for the core's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef BURNER_IGNITION_SAFETY_CORE_ASSERT_SVH
`define BURNER_IGNITION_SAFETY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define BIS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bis: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define BIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bis: next-cycle check failed");

`endif

// ----- hdl/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// Burner ignition safety package
// Shared types, codes and constant tables for the burner ignition core.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RELAY = 2'd1,
    FUNC_VALVE = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_IGNITION = 2'd1,
    CFG_PWM_MIN  = 2'd2,
    CFG_BYPASS   = 2'd3
  } cfg_idx_e;

  // Relay bit positions
  localparam int          RELAY_NUM  = 5;
  localparam logic [2:0]  RELAY_FUEL = 3'd3;
  localparam logic [2:0]  RELAY_IGN  = 3'd4;

  // Field widths
  localparam int CFG_DATA_W = 17;
  localparam int VALVE_PROD_W = 14;

  // Percent and duty scaling
  localparam int         PctFull   = 100;
  localparam int         DutyFull  = 255;
  localparam logic [6:0] PCT_MAX   = 7'(PctFull);
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x below 16384
  localparam int         RECIP_SHIFT = 20;
  localparam logic [14:0] RECIP_100  = 15'd10486;

  // Duty byte for each percent value
  typedef logic [7:0] duty_lut_t [128];

  function automatic duty_lut_t build_duty_lut();
    duty_lut_t lut;
    int        d;
    for (int i = 0; i < 128; i++) begin
      d = (i * DutyFull) / PctFull;
      lut[i] = (d > DutyFull) ? 8'hFF : 8'(d);
    end
    return lut;
  endfunction

  localparam duty_lut_t DUTY_LUT = build_duty_lut();

  // Configuration register set
  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [16:0] ignition_ms;
    logic [6:0]  pwm_min_percent;
    logic        flame_bypass;
  } cfg_t;

  // One accepted input item
  typedef struct packed {
    func_e              func;
    logic               flame_raw;
    logic [2:0]         relay_select;
    logic               relay_on;
    logic signed [15:0] valve_request;
  } item_t;

  // State snapshot after one item, in pre-scaled valve form
  typedef struct packed {
    logic [RELAY_NUM-1:0]    relay_bits;
    logic [VALVE_PROD_W-1:0] valve_prod;
    logic [6:0]              valve_min;
    logic                    valve_on;
    logic                    flame_present;
    logic                    safety_shutoff;
  } res_t;

endpackage

// ----- hdl/bis_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Burner ignition configuration registers
// Holds debounce and ignition limits, minimum valve opening and bypass.
// ----------------------------------------------------------------------------
module bis_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bis_pkg::cfg_t                     cfg
);

  bis_pkg::cfg_t cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms     <= 16'd50;
      cfg_r.ignition_ms     <= 17'd5000;
      cfg_r.pwm_min_percent <= 7'd30;
      cfg_r.flame_bypass    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (bis_pkg::cfg_idx_e'(cfg_index))
        bis_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms     <= cfg_wdata[15:0];
        bis_pkg::CFG_IGNITION: cfg_r.ignition_ms     <= cfg_wdata[16:0];
        bis_pkg::CFG_PWM_MIN:  cfg_r.pwm_min_percent <= cfg_wdata[6:0];
        bis_pkg::CFG_BYPASS:   cfg_r.flame_bypass    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/bis_ctrl.sv -----
// ----------------------------------------------------------------------------
// Burner ignition control state
// Flame debounce, ignition safety rules, relay commands and valve request.
// ----------------------------------------------------------------------------
module bis_ctrl #(
  parameter int TIMER_BITS = 18
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  bis_pkg::item_t item,
  input  bis_pkg::cfg_t  cfg,
  output bis_pkg::res_t  res_nxt
);

  localparam int CMP_W = (TIMER_BITS > 17) ? TIMER_BITS : 17;

  logic                               last_raw_r,  last_raw_nxt;
  logic [TIMER_BITS-1:0]              stable_r,    stable_nxt;
  logic                               flame_r,     flame_nxt;
  logic [TIMER_BITS-1:0]              ign_cnt_r,   ign_cnt_nxt;
  logic [bis_pkg::RELAY_NUM-1:0]      relay_r,     relay_nxt;
  logic [bis_pkg::VALVE_PROD_W-1:0]   vprod_r,     vprod_nxt;
  logic [6:0]                         vmin_r,      vmin_nxt;
  logic                               von_r,       von_nxt;
  logic                               shut_nxt;

  // Valve request terms
  logic [6:0] pct_req;
  logic [6:0] min_clamped;
  logic [6:0] span;
  logic       ign_on;
  logic       gas_on;

  // Clamp the request and scale into the span above the minimum
  always_comb begin
    if (item.valve_request < 16'sd0) begin
      pct_req = 7'd0;
    end else if (item.valve_request > $signed({9'd0, bis_pkg::PCT_MAX})) begin
      pct_req = bis_pkg::PCT_MAX;
    end else begin
      pct_req = item.valve_request[6:0];
    end
    min_clamped = (cfg.pwm_min_percent > bis_pkg::PCT_MAX) ? bis_pkg::PCT_MAX
                                                           : cfg.pwm_min_percent;
    span = bis_pkg::PCT_MAX - min_clamped;
  end

  assign ign_on = relay_r[bis_pkg::RELAY_IGN];
  assign gas_on = relay_r[bis_pkg::RELAY_FUEL];

  // Next state for one item
  always_comb begin
    last_raw_nxt = last_raw_r;
    stable_nxt   = stable_r;
    flame_nxt    = flame_r;
    ign_cnt_nxt  = ign_cnt_r;
    relay_nxt    = relay_r;
    vprod_nxt    = vprod_r;
    vmin_nxt     = vmin_r;
    von_nxt      = von_r;
    shut_nxt     = 1'b0;
    case (item.func)
      bis_pkg::FUNC_TICK: begin
        // Debounce the flame sample
        if (item.flame_raw != last_raw_r) begin
          stable_nxt = '0;
        end else if (stable_r != '1) begin
          stable_nxt = stable_r + 1'b1;
        end
        if (CMP_W'(stable_nxt) > CMP_W'(cfg.debounce_ms)) begin
          flame_nxt = !item.flame_raw;
        end
        last_raw_nxt = item.flame_raw;
        if (ign_cnt_r != '1) begin
          ign_cnt_nxt = ign_cnt_r + 1'b1;
        end
        // Safety rules, first match wins
        if (!cfg.flame_bypass) begin
          if (ign_on && !flame_nxt) begin
            if (CMP_W'(ign_cnt_nxt) > CMP_W'(cfg.ignition_ms)) begin
              relay_nxt[bis_pkg::RELAY_FUEL] = 1'b0;
              relay_nxt[bis_pkg::RELAY_IGN]  = 1'b0;
              ign_cnt_nxt = '0;
              shut_nxt    = 1'b1;
            end
          end else if (ign_on && flame_nxt) begin
            relay_nxt[bis_pkg::RELAY_IGN] = 1'b0;
            ign_cnt_nxt = '0;
          end else if (!ign_on && gas_on && von_r && !flame_nxt) begin
            relay_nxt[bis_pkg::RELAY_IGN] = 1'b1;
            ign_cnt_nxt = '0;
          end
        end
      end
      bis_pkg::FUNC_RELAY: begin
        // Drop selects past the ignitor
        if (item.relay_select <= bis_pkg::RELAY_IGN) begin
          relay_nxt[item.relay_select] = item.relay_on;
          if (item.relay_select == bis_pkg::RELAY_IGN) begin
            ign_cnt_nxt = '0;
          end
        end
      end
      bis_pkg::FUNC_VALVE: begin
        von_nxt   = (pct_req != 7'd0);
        vmin_nxt  = min_clamped;
        vprod_nxt = bis_pkg::VALVE_PROD_W'({7'd0, span} * {7'd0, pct_req});
      end
      default: ;
    endcase
  end

  // Commit state when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b1;
      stable_r   <= '0;
      flame_r    <= 1'b0;
      ign_cnt_r  <= '0;
      relay_r    <= '0;
      vprod_r    <= '0;
      vmin_r     <= '0;
      von_r      <= 1'b0;
    end else if (step) begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      flame_r    <= flame_nxt;
      ign_cnt_r  <= ign_cnt_nxt;
      relay_r    <= relay_nxt;
      vprod_r    <= vprod_nxt;
      vmin_r     <= vmin_nxt;
      von_r      <= von_nxt;
    end
  end

  // Snapshot of the state after this item
  always_comb begin
    res_nxt.relay_bits     = relay_nxt;
    res_nxt.valve_prod     = vprod_nxt;
    res_nxt.valve_min      = vmin_nxt;
    res_nxt.valve_on       = von_nxt;
    res_nxt.flame_present  = flame_nxt;
    res_nxt.safety_shutoff = shut_nxt;
  end

endmodule

// ----- hdl/bis_valve_fmt.sv -----
// ----------------------------------------------------------------------------
// Burner ignition valve formatter
// Turns the held valve product into the percent and the PWM duty byte.
// ----------------------------------------------------------------------------
module bis_valve_fmt (
  input  bis_pkg::res_t res,
  output logic [7:0]    valve_duty,
  output logic [6:0]    valve_percent
);

  localparam int PROD_W = bis_pkg::VALVE_PROD_W + 15;

  logic [PROD_W-1:0] recip_prod;
  logic [6:0]        quot;
  logic [6:0]        pct;

  // Divide by one hundred through the reciprocal, then add the minimum
  always_comb begin
    recip_prod = PROD_W'(res.valve_prod) * PROD_W'(bis_pkg::RECIP_100);
    quot       = 7'(recip_prod >> bis_pkg::RECIP_SHIFT);
    pct        = quot + res.valve_min;
  end

  // Zero request reads back as fully closed
  assign valve_percent = res.valve_on ? pct : 7'd0;
  assign valve_duty    = res.valve_on ? bis_pkg::DUTY_LUT[pct] : 8'd0;

endmodule

// ----- hdl/burner_ignition_safety_core.sv -----
// ----------------------------------------------------------------------------
// Burner ignition safety core
// Gas burner flame safeguard: debounced flame sensing, ignition timeout
// shutoff, relay commands and valve PWM scaling, one result per item.
// ----------------------------------------------------------------------------
//   Channel   Direction  Payload
//   in_*      slave      tuser: func; tdata: flame_raw, relay_select,
//                        relay_on, valve_request
//   out_*     master     tdata: relay_bits, valve_duty, valve_percent,
//                        flame_present, safety_shutoff
//   cfg_*     write      index 0 debounce_ms, 1 ignition_ms,
//                        2 pwm_min_percent, 3 flame_bypass
//
// One item per cycle sustained while results are taken; an item passes the
// input register, then the result register, before its result is valid.
// Reset is synchronous on rst_n; no clearing pass, ready right after reset.
// A stalled output holds the result and the input register; input keeps
// flowing as long as the result register is empty or being taken.
// ----------------------------------------------------------------------------
module burner_ignition_safety_core #(
  parameter int TIMER_BITS = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [0] flame_raw, [3:1] relay_select, [4] relay_on, [20:5] valve_request
  input  logic [23:0]                    in_tdata,
  // [1:0] func
  input  logic [1:0]                     in_tuser,
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [4:0] relay_bits, [12:5] valve_duty, [19:13] valve_percent,
  // [20] flame_present, [21] safety_shutoff
  output logic [23:0]                    out_tdata,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bis_pkg::cfg_t  cfg;
  bis_pkg::item_t in_item_r;
  logic           in_vld_r;
  bis_pkg::res_t  res_nxt;
  bis_pkg::res_t  res_r;
  logic           out_vld_r;
  logic           advance;
  logic [7:0]     valve_duty;
  logic [6:0]     valve_percent;

  // Handshake control
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.func          <= bis_pkg::func_e'(in_tuser);
      in_item_r.flame_raw     <= in_tdata[0];
      in_item_r.relay_select  <= in_tdata[3:1];
      in_item_r.relay_on      <= in_tdata[4];
      in_item_r.valve_request <= $signed(in_tdata[20:5]);
    end
  end

  bis_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bis_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  bis_valve_fmt u_fmt (
    .res           (res_r),
    .valve_duty    (valve_duty),
    .valve_percent (valve_percent)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r.safety_shutoff, res_r.flame_present,
                       valve_percent, valve_duty, res_r.relay_bits};

`include "burner_ignition_safety_core_assert.svh"

  // A shutoff result shows gas and ignitor both off
  `BIS_ASSERT_IMPLY(a_shutoff_relays_off, out_vld_r && res_r.safety_shutoff,
    !res_r.relay_bits[bis_pkg::RELAY_FUEL] && !res_r.relay_bits[bis_pkg::RELAY_IGN])

  // Input only stalls behind a held item and a stalled result
  `BIS_ASSERT_IMPLY(a_stall_cause, !in_tready, in_vld_r && out_vld_r && !out_tready)

  // An advanced item always yields a result next cycle
  `BIS_ASSERT_NEXT(a_advance_result, advance, out_vld_r)

  // Bypass never produces a shutoff
  `BIS_ASSERT_NEXT(a_bypass_no_shutoff, advance && cfg.flame_bypass, !res_r.safety_shutoff)

endmodule

// ----- bench/burner_ignition_safety_core_tb.sv -----
// ----------------------------------------------------------------------------
// Burner ignition safety core testbench
// Drives relay, valve, flame tick and unused-code items into the core under
// several register settings and idle patterns. Every result transfer is
// compared field by field with an in-order queue filled by a cycle-free
// model of the burner state or by the script's fixed expectations.
// ----------------------------------------------------------------------------
module burner_ignition_safety_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TIMER_BITS      = 18;
  localparam logic [17:0] TIMER_TOP       = '1;
  localparam logic [1:0]  FUNC_UNKNOWN    = 2'd3;
  localparam int          PRESSURE_CYCLES = 300;
  localparam int          DRAIN_CYCLES    = 4;

  // One input item, fields as the core sees them
  typedef struct packed {
    logic [1:0]         kind;
    logic               flame_raw;
    logic [2:0]         sel;
    logic               on;
    logic signed [15:0] valve;
  } burner_cmd_t;

  // One result, laid out as out_tdata[21:0]
  typedef struct packed {
    logic       shutoff;
    logic       flame;
    logic [6:0] pct;
    logic [7:0] duty;
    logic [4:0] relays;
  } burner_status_t;

  typedef struct {
    burner_cmd_t    cmd;
    bit             typed;
    burner_status_t want;
  } script_row_t;

  typedef struct {
    int unsigned deb;
    int unsigned ign;
    int unsigned pwm;
    int unsigned byp;
    int unsigned send_idle;
    int unsigned recv_stall;
    int unsigned items;
    bit          squeeze;
  } phase_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Burner state mirror and register copies
  logic        sense_last  = 1'b1;
  logic [17:0] stable_ms   = '0;
  logic        flame_ok    = 1'b0;
  logic [17:0] ignite_ms   = '0;
  logic [4:0]  relays      = '0;
  logic [7:0]  duty_reg    = '0;
  logic [6:0]  pct_reg     = '0;
  logic [15:0] lim_debounce = 16'd50;
  logic [16:0] lim_ignition = 17'd5000;
  logic [6:0]  min_open     = 7'd30;
  logic        rules_off    = 1'b0;

  burner_status_t pending_status[$];
  int unsigned    mismatches     = 0;
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_req       = 0;
  logic           sensor_level   = 1'b1;

  phase_t plan [6] = '{
    '{0,     3,      0,   0, 0,  0,  200, 1'b0},
    '{2,     10,     100, 0, 50, 0,  200, 1'b0},
    '{1,     0,      127, 0, 0,  50, 200, 1'b1},
    '{3,     6,      45,  1, 7,  7,  150, 1'b0},
    '{65535, 131071, 30,  0, 0,  0,  150, 1'b0},
    '{1,     4,      70,  0, 7,  7,  250, 1'b0}
  };

  burner_ignition_safety_core #(
    .TIMER_BITS(TIMER_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("burner_ignition_safety_core_tb: FAIL");
    $finish;
  end

  function automatic burner_cmd_t mk_tick(logic raw);
    burner_cmd_t cmd;
    cmd = '0;
    cmd.kind = bis_pkg::FUNC_TICK;
    cmd.flame_raw = raw;
    return cmd;
  endfunction

  function automatic burner_cmd_t mk_relay(logic [2:0] sel, logic on);
    burner_cmd_t cmd;
    cmd = '0;
    cmd.kind = bis_pkg::FUNC_RELAY;
    cmd.sel = sel;
    cmd.on = on;
    return cmd;
  endfunction

  function automatic burner_cmd_t mk_valve(int req);
    burner_cmd_t cmd;
    cmd = '0;
    cmd.kind = bis_pkg::FUNC_VALVE;
    cmd.valve = 16'(req);
    return cmd;
  endfunction

  function automatic burner_status_t mk_status(logic [4:0] rel, logic [7:0] duty,
                                               logic [6:0] pct, logic flame, logic shut);
    burner_status_t st;
    st.relays = rel;
    st.duty = duty;
    st.pct = pct;
    st.flame = flame;
    st.shutoff = shut;
    return st;
  endfunction

  // Apply one item to the mirrored burner state and return the status after it
  function automatic burner_status_t advance_burner(burner_cmd_t cmd);
    burner_status_t st;
    logic           shut;
    int             req;
    int             floor_min;
    int             scaled;
    shut = 1'b0;
    case (cmd.kind)
      bis_pkg::FUNC_TICK: begin
        // Debounce: restart on a change, else count up and hold at the top
        if (cmd.flame_raw != sense_last) begin
          stable_ms = '0;
        end else if (stable_ms != TIMER_TOP) begin
          stable_ms = stable_ms + 1'b1;
        end
        if (stable_ms > lim_debounce) flame_ok = ~cmd.flame_raw;
        sense_last = cmd.flame_raw;
        if (ignite_ms != TIMER_TOP) ignite_ms = ignite_ms + 1'b1;
        // Safety rules, first match wins
        if (!rules_off) begin
          if (relays[bis_pkg::RELAY_IGN] && !flame_ok) begin
            if (ignite_ms > lim_ignition) begin
              relays[bis_pkg::RELAY_FUEL] = 1'b0;
              relays[bis_pkg::RELAY_IGN] = 1'b0;
              ignite_ms = '0;
              shut = 1'b1;
            end
          end else if (relays[bis_pkg::RELAY_IGN]) begin
            relays[bis_pkg::RELAY_IGN] = 1'b0;
            ignite_ms = '0;
          end else if (relays[bis_pkg::RELAY_FUEL] && duty_reg != 0 && !flame_ok) begin
            relays[bis_pkg::RELAY_IGN] = 1'b1;
            ignite_ms = '0;
          end
        end
      end
      bis_pkg::FUNC_RELAY: begin
        if (cmd.sel < bis_pkg::RELAY_NUM) begin
          relays[cmd.sel] = cmd.on;
          if (cmd.sel == bis_pkg::RELAY_IGN) ignite_ms = '0;
        end
      end
      bis_pkg::FUNC_VALVE: begin
        req = int'($signed(cmd.valve));
        if (req > bis_pkg::PctFull) req = bis_pkg::PctFull;
        if (req < 0) req = 0;
        if (req == 0) begin
          pct_reg = '0;
          duty_reg = '0;
        end else begin
          floor_min = (min_open > bis_pkg::PctFull) ? bis_pkg::PctFull : int'(min_open);
          scaled = ((bis_pkg::PctFull - floor_min) * req) / bis_pkg::PctFull + floor_min;
          pct_reg = 7'(scaled);
          duty_reg = 8'((scaled * bis_pkg::DutyFull) / bis_pkg::PctFull);
        end
      end
      default: ;
    endcase
    st = mk_status(relays, duty_reg, pct_reg, flame_ok, shut);
    return st;
  endfunction

  // Random item, biased toward ignition sequences with a slowly changing sensor
  function automatic burner_cmd_t random_cmd();
    burner_cmd_t cmd;
    int unsigned pick;
    cmd.kind = FUNC_UNKNOWN;
    cmd.flame_raw = 1'($urandom);
    cmd.sel = 3'($urandom);
    cmd.on = 1'($urandom);
    cmd.valve = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 50) begin
      cmd.kind = bis_pkg::FUNC_TICK;
      if ($urandom_range(9) == 0) sensor_level = ~sensor_level;
      cmd.flame_raw = ($urandom_range(19) == 0) ? ~sensor_level : sensor_level;
    end else if (pick < 72) begin
      cmd.kind = bis_pkg::FUNC_RELAY;
      pick = $urandom_range(9);
      if (pick < 3) cmd.sel = bis_pkg::RELAY_FUEL;
      else if (pick < 6) cmd.sel = bis_pkg::RELAY_IGN;
      cmd.on = ($urandom_range(2) != 0);
    end else if (pick < 93) begin
      cmd.kind = bis_pkg::FUNC_VALVE;
      if ($urandom_range(9) >= 2) cmd.valve = 16'(int'($urandom_range(125)) - 10);
    end
    return cmd;
  endfunction

  task automatic write_reg(bis_pkg::cfg_idx_e idx, logic [bis_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      bis_pkg::CFG_DEBOUNCE: lim_debounce = val[15:0];
      bis_pkg::CFG_IGNITION: lim_ignition = val[16:0];
      bis_pkg::CFG_PWM_MIN:  min_open = val[6:0];
      bis_pkg::CFG_BYPASS:   rules_off = val[0];
      default: ;
    endcase
  endtask

  task automatic program_settings(int unsigned deb, int unsigned ign,
                                  int unsigned pwm, int unsigned byp);
    write_reg(bis_pkg::CFG_DEBOUNCE, bis_pkg::CFG_DATA_W'(deb));
    write_reg(bis_pkg::CFG_IGNITION, bis_pkg::CFG_DATA_W'(ign));
    write_reg(bis_pkg::CFG_PWM_MIN, bis_pkg::CFG_DATA_W'(pwm));
    write_reg(bis_pkg::CFG_BYPASS, bis_pkg::CFG_DATA_W'(byp));
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one item, wait for its transfer, then queue the expected status
  task automatic send_cmd(burner_cmd_t cmd, bit typed, burner_status_t want);
    burner_status_t seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd.kind;
    in_tdata <= {3'b000, cmd.valve, cmd.on, cmd.sel, cmd.flame_raw};
    do @(posedge clk); while (!in_tready);
    seen = advance_burner(cmd);
    pending_status.push_back(typed ? want : seen);
  endtask

  // Drop valid and wait until every queued status has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin : result_sink
    int unsigned hold_ack;
    int unsigned hold_left;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = PRESSURE_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    burner_status_t got;
    burner_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = burner_status_t'(out_tdata[21:0]);
      if (pending_status.size() == 0) begin
        $error("unexpected result transfer, tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("relay_bits", want.relays, got.relays);
        check_field("valve_duty", want.duty, got.duty);
        check_field("valve_percent", want.pct, got.pct);
        check_field("flame_present", want.flame, got.flame);
        check_field("safety_shutoff", want.shutoff, got.shutoff);
      end
    end
  end

  initial begin : stimulus
    script_row_t    script[$];
    burner_status_t none;
    none = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fast debounce and a short ignition window
    script = '{
      '{burner_cmd_t'({FUNC_UNKNOWN, 21'd0}), 1'b1,
        mk_status(5'd0, 8'd0, 7'd0, 1'b0, 1'b0)},
      '{mk_valve(-32768), 1'b1, mk_status(5'd0, 8'd0, 7'd0, 1'b0, 1'b0)},
      '{mk_valve(32767), 1'b1, mk_status(5'd0, 8'd255, 7'd100, 1'b0, 1'b0)},
      '{mk_relay(3'd7, 1'b1), 1'b1, mk_status(5'd0, 8'd255, 7'd100, 1'b0, 1'b0)},
      '{mk_relay(bis_pkg::RELAY_FUEL, 1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b1, mk_status(5'd0, 8'd255, 7'd100, 1'b0, 1'b1)},
      '{mk_valve(1), 1'b0, none},
      '{mk_valve(101), 1'b0, none},
      '{mk_valve(50), 1'b0, none},
      '{mk_relay(bis_pkg::RELAY_FUEL, 1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_tick(1'b0), 1'b0, none},
      '{mk_tick(1'b0), 1'b0, none},
      '{mk_relay(3'd0, 1'b1), 1'b0, none},
      '{mk_relay(3'd1, 1'b1), 1'b0, none},
      '{mk_relay(3'd2, 1'b1), 1'b0, none},
      '{mk_relay(bis_pkg::RELAY_IGN, 1'b1), 1'b0, none},
      '{mk_tick(1'b0), 1'b0, none},
      '{mk_relay(3'd0, 1'b0), 1'b0, none},
      '{mk_valve(0), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_tick(1'b1), 1'b0, none},
      '{mk_relay(bis_pkg::RELAY_FUEL, 1'b0), 1'b0, none}
    };
    program_settings(0, 2, 30, 0);
    foreach (script[i]) send_cmd(script[i].cmd, script[i].typed, script[i].want);
    drain();

    // Random phases over settings and idle patterns
    foreach (plan[p]) begin
      program_settings(plan[p].deb, plan[p].ign, plan[p].pwm, plan[p].byp);
      send_idle_pct = plan[p].send_idle;
      recv_stall_pct = plan[p].recv_stall;
      if (plan[p].squeeze) hold_req++;
      repeat (plan[p].items) send_cmd(random_cmd(), 1'b0, none);
      drain();
    end

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("burner_ignition_safety_core_tb: PASS");
    end else begin
      $display("burner_ignition_safety_core_tb: FAIL");
    end
    $finish;
  end

endmodule
